// ----- hw/rtl/rcdt_pkg.sv -----
// Package for the relay channel delay timer.
// Shared constants, register indexes and front-to-back command struct.
package rcdt_pkg;
  localparam int unsigned CHANNELS_DEF  = 8;
  localparam int unsigned TICK_BITS_DEF = 32;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ON_DELAYS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAYS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENTS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STAIRCASE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRITABLE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLAGS      = 3'd5;

  localparam logic [1:0] CMD_OFF  = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_TICK = 2'd1,
    OP_OFF  = 2'd2,
    OP_ON   = 2'd3
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] channel;
    logic       read;
  } job_t;
endpackage

// ----- hw/rtl/rcdt_front.sv -----
// Front end: accepts items, checks enables and classifies them into jobs.
// Depends on rcdt_pkg.
module rcdt_front #(
  parameter int unsigned CHANNELS = rcdt_pkg::CHANNELS_DEF
) (
  input  logic             func_i,
  input  logic [2:0]       channel_i,
  input  logic [1:0]       command_i,
  input  logic [7:0]       writable_i,
  input  logic [23:0]      flags_i,
  output rcdt_pkg::job_t   job_o
);
  logic [2:0] fl;
  logic       in_range;

  always_comb begin
    fl       = flags_i[3*channel_i +: 3];
    in_range = ({1'b0, channel_i} < 4'(CHANNELS));
    job_o.op      = rcdt_pkg::OP_NONE;
    job_o.channel = channel_i;
    job_o.read    = 1'b0;
    if (!func_i) begin
      job_o.op = rcdt_pkg::OP_TICK;
    end else if (in_range && fl[0]) begin
      if (writable_i[channel_i] && fl[2]) begin
        if (command_i == rcdt_pkg::CMD_OFF) job_o.op = rcdt_pkg::OP_OFF;
        else if (command_i == rcdt_pkg::CMD_ON) job_o.op = rcdt_pkg::OP_ON;
      end
      job_o.read = (command_i == rcdt_pkg::CMD_READ) && fl[1];
    end
  end
endmodule

// ----- hw/rtl/rcdt_queue.sv -----
// Short job queue between front end and back end.
// Depends on rcdt_pkg.
module rcdt_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rcdt_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output rcdt_pkg::job_t data_o,
  output logic           empty_o
);
  localparam int unsigned D = rcdt_pkg::QUEUE_DEPTH;
  localparam int unsigned AW = $clog2(D);

  rcdt_pkg::job_t   mem_q [D];
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(D));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= wp_q + 1'b1;
      if (pop_i && !empty_o) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i && !full_o) - (AW+1)'(pop_i && !empty_o);
    end
  end
endmodule

// ----- hw/rtl/rcdt_back.sv -----
// Back end: executes jobs, holds counter and pending entries, scans on ticks.
// Depends on rcdt_pkg.
module rcdt_back #(
  parameter int unsigned CHANNELS  = rcdt_pkg::CHANNELS_DEF,
  parameter int unsigned TICK_BITS = rcdt_pkg::TICK_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  rcdt_pkg::job_t job_i,
  output logic           job_pop_o,
  input  logic [63:0]    on_delays_i,
  input  logic [63:0]    off_delays_i,
  input  logic [31:0]    exponents_i,
  input  logic [7:0]     staircase_i,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output logic [7:0]     port_state_o,
  output logic           reply_valid_o,
  output logic           reply_on_o
);
  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_OUT} state_e;

  state_e                 state_q;
  logic [TICK_BITS-1:0]   tick_q;
  logic [7:0]             out_q;
  logic [7:0]             armed_q, turns_on_q;
  logic [TICK_BITS-1:0]   target_q [8];
  logic [2:0]             idx_q;
  logic                   rv_q, ro_q;

  logic [2:0]             ach;
  logic                   aon, do_arm;
  logic [7:0]             acnt;
  logic [3:0]             ash;
  logic [TICK_BITS-1:0]   atgt, tick_use;
  logic [7:0]             offd, ond;
  logic                   stair, hit;

  always_comb begin
    ach = job_i.channel; aon = 1'b0; do_arm = 1'b0; acnt = '0;
    tick_use = tick_q;
    offd  = off_delays_i[8*job_i.channel +: 8];
    ond   = on_delays_i[8*job_i.channel +: 8];
    stair = staircase_i[job_i.channel];
    hit   = 1'b0;
    if (state_q == ST_SCAN) begin
      ach  = idx_q;
      offd = off_delays_i[8*idx_q +: 8];
      hit  = armed_q[idx_q] && (target_q[idx_q] == tick_q) &&
             ({1'b0, idx_q} < 4'(CHANNELS));
      if (hit && turns_on_q[idx_q] && staircase_i[idx_q] && offd != 8'd0) begin
        do_arm = 1'b1; acnt = offd;
      end
    end else if (job_i.op == rcdt_pkg::OP_OFF) begin
      if (!(offd == 8'd0 || stair)) begin do_arm = 1'b1; acnt = offd; end
    end else if (job_i.op == rcdt_pkg::OP_ON) begin
      if (ond != 8'd0) begin do_arm = 1'b1; aon = 1'b1; acnt = ond; end
      else if (stair) begin do_arm = 1'b1; acnt = offd; end
    end
    ash  = exponents_i[4*ach +: 4];
    atgt = (TICK_BITS'(acnt) << ash) + tick_use;
  end

  assign job_pop_o     = (state_q == ST_IDLE) && job_valid_i;
  assign res_valid_o   = (state_q == ST_OUT);
  assign port_state_o  = out_q;
  assign reply_valid_o = rv_q;
  assign reply_on_o    = ro_q;

  always_ff @(posedge clk_i) begin
    if (do_arm && (state_q == ST_SCAN || job_pop_o))
      target_q[ach] <= atgt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; tick_q <= '0; out_q <= '0;
      armed_q <= '0; turns_on_q <= '0; idx_q <= '0; rv_q <= 1'b0; ro_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: if (job_valid_i) begin
          rv_q <= job_i.read;
          ro_q <= job_i.read & out_q[job_i.channel];
          case (job_i.op)
            rcdt_pkg::OP_TICK: begin
              tick_q <= tick_q + 1'b1; idx_q <= '0; state_q <= ST_SCAN;
            end
            rcdt_pkg::OP_OFF: begin
              if (do_arm) begin
                armed_q[ach] <= 1'b1; turns_on_q[ach] <= 1'b0;
              end else out_q[job_i.channel] <= 1'b0;
              state_q <= ST_OUT;
            end
            rcdt_pkg::OP_ON: begin
              if (do_arm) begin
                armed_q[ach] <= 1'b1; turns_on_q[ach] <= aon;
              end
              if (ond == 8'd0) out_q[job_i.channel] <= 1'b1;
              state_q <= ST_OUT;
            end
            default: state_q <= ST_OUT;
          endcase
        end
        ST_SCAN: begin
          if (hit) begin
            armed_q[idx_q] <= do_arm;
            turns_on_q[idx_q] <= 1'b0;
            out_q[idx_q] <= turns_on_q[idx_q];
          end
          if ({1'b0, idx_q} == 4'(CHANNELS - 1)) state_q <= ST_OUT;
          idx_q <= idx_q + 1'b1;
        end
        ST_OUT: if (res_ready_i) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule

// ----- hw/rtl/relay_channel_delay_timer_core.sv -----
// Relay channel delay timer, top level.
// Commands go from the idle state straight to the result state; ticks first pass
// through a scan state, a one-comparator scan over the pending entries.
// A two-item job queue lets input accept while the back end works.
// Reset (async, active low) clears counter, outputs, entry flags, registers; writable resets to all ones.
// Depends on rcdt_pkg, rcdt_front, rcdt_queue, rcdt_back.
module relay_channel_delay_timer_core #(
  parameter int unsigned CHANNELS  = rcdt_pkg::CHANNELS_DEF,
  parameter int unsigned TICK_BITS = rcdt_pkg::TICK_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // channel[2:0], command[4:3], zero
  input  logic        s_axis_tuser,  // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // port_state[7:0], reply_valid, reply_on, zero
  input  logic        cfg_we_i,
  input  logic [rcdt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rcdt_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  logic [63:0] on_q, off_q;
  logic [31:0] exp_q;
  logic [7:0]  stair_q, wr_q;
  logic [23:0] flags_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q <= '0; off_q <= '0; exp_q <= '0; stair_q <= '0; wr_q <= 8'hFF; flags_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rcdt_pkg::REG_ON_DELAYS:  on_q    <= cfg_data_i;
        rcdt_pkg::REG_OFF_DELAYS: off_q   <= cfg_data_i;
        rcdt_pkg::REG_EXPONENTS:  exp_q   <= cfg_data_i[31:0];
        rcdt_pkg::REG_STAIRCASE:  stair_q <= cfg_data_i[7:0];
        rcdt_pkg::REG_WRITABLE:   wr_q    <= cfg_data_i[7:0];
        rcdt_pkg::REG_FLAGS:      flags_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  rcdt_pkg::job_t job_in, job_out;
  logic full, empty, pop;
  logic [7:0] ps;
  logic rv, ro;

  rcdt_front #(.CHANNELS(CHANNELS)) u_front (
    .func_i(s_axis_tuser), .channel_i(s_axis_tdata[2:0]), .command_i(s_axis_tdata[4:3]),
    .writable_i(wr_q), .flags_i(flags_q), .job_o(job_in)
  );

  assign s_axis_tready = !full;

  rcdt_queue u_queue (
    .clk_i, .rst_ni, .push_i(s_axis_tvalid), .data_i(job_in), .full_o(full),
    .pop_i(pop), .data_o(job_out), .empty_o(empty)
  );

  rcdt_back #(.CHANNELS(CHANNELS), .TICK_BITS(TICK_BITS)) u_back (
    .clk_i, .rst_ni, .job_valid_i(!empty), .job_i(job_out), .job_pop_o(pop),
    .on_delays_i(on_q), .off_delays_i(off_q), .exponents_i(exp_q),
    .staircase_i(stair_q), .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .port_state_o(ps), .reply_valid_o(rv), .reply_on_o(ro)
  );

  assign m_axis_tdata = {6'd0, ro, rv, ps};
endmodule

// ----- hw/rtl/rcdt_checker.sv -----
// Port-level checker for the relay channel delay timer.
// Bound to relay_channel_delay_timer_core.
module rcdt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[8] |-> !m_axis_tdata[9])
    else $error("reply_on without reply_valid");
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:10] == 6'd0)
    else $error("padding nonzero");
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("result repeated");
endmodule

bind relay_channel_delay_timer_core rcdt_checker u_chk (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
